/* rtl/cpf_pkg.sv */
package cpf_pkg;

  // Default framing limits
  localparam int MaxPayloadDef = 255;
  localparam int QueueDepthDef = 2;

  // Start marker after reset
  localparam logic [7:0] StartByteRst = 8'h3E;

  // CRC-16 generator polynomial
  localparam logic [15:0] CrcPoly = 16'h8005;

  // One classified request handed from front to back
  typedef struct packed {
    logic       hdr;         // emit start, id, len, header checksum first
    logic       has_data;    // emit the payload byte
    logic       crc_end;     // close the packet with the two CRC bytes
    logic [7:0] cmd_id;
    logic [7:0] payload_len;
    logic [7:0] data_byte;
  } job_t;

endpackage

/* rtl/cpf_in_if.sv */
interface cpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_id;
  logic [7:0] payload_len;
  logic [7:0] data_byte;

  modport source (output valid, cmd_id, payload_len, data_byte, input ready);
  modport sink   (input valid, cmd_id, payload_len, data_byte, output ready);
endinterface

/* rtl/cpf_out_if.sv */
interface cpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;

  modport source (output valid, out_byte, packet_end, input ready);
  modport sink   (input valid, out_byte, packet_end, output ready);
endinterface

/* rtl/cpf_cfg_if.sv */
interface cpf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/command_packet_framer_crc16_unit.sv */
// Command packet framer with CRC-16 (poly 0x8005, init 0) trailer. Each input
// request carries cmd_id, payload_len and data_byte; the first request of a
// packet latches the length and produces start byte, id, length, header
// checksum and its payload byte, later requests produce one payload byte each,
// and the last one (or the first, when the length is zero) adds CRC low and
// high bytes, packet_end marking the high byte. A length above MAX_PAYLOAD is
// swallowed with no output. The front end accepts one request per cycle while
// its job queue (QUEUE_DEPTH entries) has room; the back end sends one byte
// per cycle while the receiver is ready, a payload request giving one byte, a
// packet's first request five (four with zero length) and the closing CRC two
// more. Sustained rate is set by that single output byte port. The start byte
// register resets to 0x3E and should be written only while the framer is idle.
module command_packet_framer_crc16_unit
  import cpf_pkg::*;
#(
  parameter int MAX_PAYLOAD = MaxPayloadDef,
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpf_cfg_if.sink   cfg_i,
  cpf_in_if.sink    in_ch_i,
  cpf_out_if.source out_ch_o
);

  logic [7:0] start_byte_q;
  logic       push, full, pop, head_valid;
  job_t       push_job, head_job;

  // Start marker register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteRst;
    end else if (cfg_i.valid) begin
      start_byte_q <= cfg_i.data;
    end
  end

  cpf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  cpf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_job)
  );

  cpf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_byte_i (start_byte_q),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_o        (out_ch_o)
  );

endmodule

/* rtl/cpf_front.sv */
module cpf_front
  import cpf_pkg::*;
#(
  parameter int MAX_PAYLOAD = MaxPayloadDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpf_in_if.sink    in_i,
  input  logic      full_i,
  output logic      push_o,
  output job_t      job_o
);

  localparam int         IdxW   = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] held_len_q, held_len_d;
  logic [IdxW-1:0] idx_inc;
  logic            accept;
  logic            drop;

  assign in_i.ready = ~full_i;
  assign accept     = in_i.valid & in_i.ready;
  assign idx_inc    = idx_q + IdxW'(1);

  // Classify the request against the open packet
  always_comb begin
    idx_d           = idx_q;
    held_len_d      = held_len_q;
    drop            = 1'b0;
    job_o.cmd_id      = in_i.cmd_id;
    job_o.payload_len = in_i.payload_len;
    job_o.data_byte   = in_i.data_byte;
    if (idx_q == '0) begin
      // first request of a packet: header, maybe payload, maybe trailer
      drop           = in_i.payload_len > MaxLen;
      job_o.hdr      = 1'b1;
      job_o.has_data = in_i.payload_len != 8'd0;
      job_o.crc_end  = in_i.payload_len <= 8'd1;
      if (accept && !drop) begin
        held_len_d = IdxW'(in_i.payload_len);
        idx_d      = (in_i.payload_len <= 8'd1) ? '0 : IdxW'(1);
      end
    end else begin
      job_o.hdr      = 1'b0;
      job_o.has_data = 1'b1;
      job_o.crc_end  = idx_inc == held_len_q;
      if (accept) begin
        idx_d = (idx_inc == held_len_q) ? '0 : idx_inc;
      end
    end
  end

  assign push_o = accept & ~drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      held_len_q <= '0;
    end else begin
      idx_q      <= idx_d;
      held_len_q <= held_len_d;
    end
  end

endmodule

/* rtl/cpf_queue.sv */
module cpf_queue
  import cpf_pkg::*;
#(
  parameter int DEPTH = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output job_t head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign full_o       = cnt_q == CntW'(DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i & head_valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* rtl/cpf_back.sv */
module cpf_back
  import cpf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] start_byte_i,
  input  logic       head_valid_i,
  input  job_t       head_i,
  output logic       pop_o,
  cpf_out_if.source  out_o
);

  typedef enum logic [2:0] {
    PH_START,
    PH_ID,
    PH_LEN,
    PH_HCS,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_e;

  // Shift one byte into the CRC, LSB first
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = (b[i] != c[15]) ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  phase_e      phase_q, phase_d, cur_phase;
  logic        busy_q, busy_d;
  logic [15:0] crc_q, crc_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        end_q, end_d;
  logic        emit;
  logic        last;
  logic [7:0]  hcs;
  logic [7:0]  cur_byte;
  phase_e      nxt_phase;

  assign hcs       = head_i.cmd_id + head_i.payload_len;
  assign cur_phase = busy_q ? phase_q : (head_i.hdr ? PH_START : PH_DATA);
  assign emit      = head_valid_i & (~valid_q | out_o.ready);

  // Byte selection and sequencing per phase
  always_comb begin
    cur_byte  = head_i.data_byte;
    nxt_phase = PH_START;
    last      = 1'b0;
    unique case (cur_phase)
      PH_START: begin
        cur_byte  = start_byte_i;
        nxt_phase = PH_ID;
      end
      PH_ID: begin
        cur_byte  = head_i.cmd_id;
        nxt_phase = PH_LEN;
      end
      PH_LEN: begin
        cur_byte  = head_i.payload_len;
        nxt_phase = PH_HCS;
      end
      PH_HCS: begin
        cur_byte  = hcs;
        nxt_phase = head_i.has_data ? PH_DATA : PH_CRC_LO;
      end
      PH_DATA: begin
        cur_byte  = head_i.data_byte;
        nxt_phase = PH_CRC_LO;
        last      = ~head_i.crc_end;
      end
      PH_CRC_LO: begin
        cur_byte  = crc_q[7:0];
        nxt_phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        cur_byte  = crc_q[15:8];
        last      = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  // Next state, CRC and output register
  always_comb begin
    phase_d = phase_q;
    busy_d  = busy_q;
    crc_d   = crc_q;
    valid_d = valid_q & ~out_o.ready;
    byte_d  = byte_q;
    end_d   = end_q;
    if (emit) begin
      valid_d = 1'b1;
      byte_d  = cur_byte;
      end_d   = cur_phase == PH_CRC_HI;
      busy_d  = ~last;
      phase_d = nxt_phase;
      if (cur_phase == PH_START) begin
        crc_d = '0;
      end else if (cur_phase != PH_CRC_LO && cur_phase != PH_CRC_HI) begin
        crc_d = crc_feed(crc_q, cur_byte);
      end
    end
  end

  assign pop_o = emit & last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      busy_q  <= 1'b0;
      crc_q   <= '0;
      valid_q <= 1'b0;
      byte_q  <= '0;
      end_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      busy_q  <= busy_d;
      crc_q   <= crc_d;
      valid_q <= valid_d;
      byte_q  <= byte_d;
      end_q   <= end_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.packet_end = end_q;

endmodule

/* sim/tb_command_packet_framer_crc16_unit.sv */
module tb_command_packet_framer_crc16_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cpf_pkg::*;

  // run limits
  localparam int unsigned CycleLimit   = 500_000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned RandomItems  = 160;
  localparam int unsigned StallCycles  = 400;
  localparam int unsigned PrintCap     = 40;

  // one byte of the framed stream
  typedef struct packed {
    logic [7:0] wire_byte;
    logic       last;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  cpf_cfg_if cfg_bus ();
  cpf_in_if  in_bus ();
  cpf_out_if out_bus ();

  command_packet_framer_crc16_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_bus),
    .in_ch_i (in_bus),
    .out_ch_o(out_bus)
  );

  // framer image kept by the testbench
  logic [7:0]  start_marker;
  logic [15:0] crc_acc;
  logic [7:0]  payload_done;
  logic [7:0]  open_len;

  frame_byte_t wire_bytes_due[$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_gap_max     = 0;
  int unsigned rx_gap_max     = 0;
  int unsigned rx_hold        = 0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PrintCap)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // CRC-16 0x8005, data LSB first, register shifts out its MSB
  function automatic logic [15:0] crc16_add_byte(input logic [15:0] crc,
                                                 input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = b[i] ^ c[15];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  function automatic void push_wire_byte(input logic [7:0] b, input logic last);
    frame_byte_t fb;
    fb.wire_byte = b;
    fb.last      = last;
    wire_bytes_due.push_back(fb);
  endfunction

  function automatic void push_crc_trailer();
    push_wire_byte(crc_acc[7:0], 1'b0);
    push_wire_byte(crc_acc[15:8], 1'b1);
    payload_done = 8'd0;
  endfunction

  // expected wire bytes for one accepted request
  function automatic void frame_request(input logic [7:0] id, input logic [7:0] len,
                                        input logic [7:0] data);
    logic [7:0] hcs;
    if (payload_done == 8'd0) begin
      // oversized length is swallowed, framer keeps waiting for a header
      if (int'(len) > MaxPayloadDef) return;
      open_len = len;
      hcs      = id + len;
      crc_acc  = 16'h0000;
      push_wire_byte(start_marker, 1'b0);
      push_wire_byte(id, 1'b0);
      push_wire_byte(len, 1'b0);
      push_wire_byte(hcs, 1'b0);
      crc_acc = crc16_add_byte(crc_acc, id);
      crc_acc = crc16_add_byte(crc_acc, len);
      crc_acc = crc16_add_byte(crc_acc, hcs);
      if (open_len == 8'd0) begin
        push_crc_trailer();
        return;
      end
    end
    push_wire_byte(data, 1'b0);
    crc_acc      = crc16_add_byte(crc_acc, data);
    payload_done = payload_done + 8'd1;
    if (payload_done >= open_len) push_crc_trailer();
  endfunction

  task automatic check_wire_byte(input logic [7:0] got_byte, input logic got_last);
    frame_byte_t want;
    if (wire_bytes_due.size() == 0) begin
      report_mismatch("unexpected output byte", got_byte, 0);
      return;
    end
    want = wire_bytes_due.pop_front();
    if (got_byte !== want.wire_byte)
      report_mismatch("out_byte", got_byte, want.wire_byte);
    if (got_last !== want.last)
      report_mismatch("packet_end", got_last, want.last);
  endtask

  // receiver: random stalls, plus a long hold when one is requested
  initial begin
    int unsigned gap;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_bus.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      gap = (rx_gap_max > 0) ? $urandom_range(rx_gap_max, 0) : 0;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid === 1'b1));
      check_wire_byte(out_bus.out_byte, out_bus.packet_end);
    end
  end

  // one input request, valid kept high when the next follows at once
  task automatic send_request(input logic [7:0] id, input logic [7:0] len,
                              input logic [7:0] data);
    int unsigned gap;
    gap = (tx_gap_max > 0) ? $urandom_range(tx_gap_max, 0) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.cmd_id      <= id;
    in_bus.payload_len <= len;
    in_bus.data_byte   <= data;
    in_bus.valid       <= 1'b1;
    do @(posedge clk); while (!(in_bus.ready === 1'b1));
    frame_request(id, len, data);
    items_sent++;
  endtask

  // whole packet, random payload; id and len on later requests are don't-care
  task automatic send_packet(input logic [7:0] id, input logic [7:0] len);
    int unsigned count;
    count = (len == 8'd0) ? 1 : len;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == 0) send_request(id, len, 8'($urandom));
      else send_request(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_for_results();
    while (wire_bytes_due.size() != 0) @(posedge clk);
  endtask

  // start byte write, only with the framer drained and quiet
  task automatic write_start_byte(input logic [7:0] value);
    in_bus.valid <= 1'b0;
    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
    cfg_bus.data  <= value;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_bus.ready === 1'b1));
    cfg_bus.valid <= 1'b0;
    start_marker = value;
  endtask

  function automatic int unsigned pick_idle();
    case ($urandom_range(2, 0))
      0:       return 0;
      1:       return 2;
      default: return 16;
    endcase
  endfunction

  // extremes of the fields, zero length, ignored fields, checksum wrap
  task automatic test_directed();
    tx_gap_max = 0;
    rx_gap_max = 0;
    send_request(8'hFF, 8'h00, 8'hA5);   // zero length, data ignored
    send_request(8'h00, 8'h01, 8'hFF);
    send_request(8'hFF, 8'h02, 8'h00);   // header checksum wraps
    send_request(8'h12, 8'h34, 8'hFF);   // id/len ignored mid-packet
    tx_gap_max = 16;
    rx_gap_max = 16;
    send_request(8'h80, 8'h03, 8'h01);
    send_request(8'hFF, 8'hFF, 8'h80);
    send_request(8'h00, 8'h00, 8'h7F);
    send_request(8'h00, 8'h00, 8'h00);   // zero length, all zero
    send_request(8'h7F, 8'h01, 8'h80);
    send_request(8'h01, 8'h04, 8'hFF);
    send_request(8'hAA, 8'h55, 8'hFF);
    send_request(8'h55, 8'hAA, 8'hFF);
    send_request(8'h00, 8'h00, 8'hFF);
  endtask

  // start byte register: extremes, random value, back to reset value
  task automatic test_start_byte();
    logic [7:0] values [4];
    values[0] = 8'h00;
    values[1] = 8'hFF;
    values[2] = 8'($urandom);
    values[3] = StartByteRst;
    for (int i = 0; i < 4; i++) begin
      write_start_byte(values[i]);
      tx_gap_max = pick_idle();
      rx_gap_max = pick_idle();
      send_packet(8'($urandom), 8'd0);
      send_packet(8'($urandom), 8'($urandom_range(4, 1)));
    end
  endtask

  // receiver holds off while the sender keeps offering, block fills and stalls
  task automatic test_output_stall();
    tx_gap_max = 0;
    rx_gap_max = 0;
    rx_hold    = StallCycles;
    send_packet(8'($urandom), 8'd30);
    send_packet(8'($urandom), 8'd0);
    send_packet(8'($urandom), 8'd2);
  endtask

  // sender pauses mid-packet and between packets until all bytes are out
  task automatic test_sender_pause();
    tx_gap_max = 3;
    rx_gap_max = 3;
    send_request(8'h3C, 8'd6, 8'($urandom));
    send_request(8'($urandom), 8'($urandom), 8'($urandom));
    send_request(8'($urandom), 8'($urandom), 8'($urandom));
    in_bus.valid <= 1'b0;
    wait_for_results();
    for (int i = 0; i < 3; i++)
      send_request(8'($urandom), 8'($urandom), 8'($urandom));
    in_bus.valid <= 1'b0;
    wait_for_results();
    send_packet(8'($urandom), 8'd1);
  endtask

  // largest payload the block takes
  task automatic test_longest_packet();
    tx_gap_max = 2;
    rx_gap_max = 2;
    send_packet(8'($urandom), 8'd255);
  endtask

  // random packets, mostly short, with changing idling and start byte
  task automatic test_random_traffic();
    int unsigned pkt;
    int unsigned first_item;
    logic [7:0]  len;
    logic [7:0]  marker;
    pkt        = 0;
    first_item = items_sent;
    while (items_sent - first_item < RandomItems) begin
      if (pkt % 6 == 0) begin
        tx_gap_max = pick_idle();
        rx_gap_max = pick_idle();
      end
      if (pkt % 10 == 9) begin
        case ($urandom_range(3, 0))
          0:       marker = 8'h00;
          1:       marker = 8'hFF;
          default: marker = 8'($urandom);
        endcase
        write_start_byte(marker);
      end
      if (pkt == 12) len = 8'($urandom_range(140, 128));
      else len = 8'($urandom_range(10, 0));
      send_packet(8'($urandom), len);
      pkt++;
    end
  endtask

  // main sequence
  initial begin
    rst_n              <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.data       <= 8'h00;
    in_bus.valid       <= 1'b0;
    in_bus.cmd_id      <= 8'h00;
    in_bus.payload_len <= 8'h00;
    in_bus.data_byte   <= 8'h00;
    start_marker = StartByteRst;
    crc_acc      = 16'h0000;
    payload_done = 8'd0;
    open_len     = 8'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_start_byte();
    test_output_stall();
    test_sender_pause();
    test_longest_packet();
    test_random_traffic();

    in_bus.valid <= 1'b0;
    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
    if (wire_bytes_due.size() != 0)
      report_mismatch("bytes never produced", wire_bytes_due.size(), 0);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
